[hdl/cache_control_header_parser_core_assert.svh]
// Assertion macros shared by the parser RTL.
// Both sample on clk_i and are disabled while rst_ni is low.
`ifndef CACHE_CONTROL_HEADER_PARSER_CORE_ASSERT_SVH
`define CACHE_CONTROL_HEADER_PARSER_CORE_ASSERT_SVH

// same-cycle implication
`define CCP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CCP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/ccp_pkg.sv]
package ccp_pkg;

  localparam int unsigned KW_NUM    = 10;
  localparam int unsigned FLAGS_W   = 14;
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned POS_W     = 5;
  localparam int unsigned S_TDATA_W = 8;
  localparam int unsigned S_TUSER_W = 2;
  localparam int unsigned M_TDATA_W = 80;

  // keyword indexes
  localparam logic [3:0] KW_NO_CACHE  = 4'd0;
  localparam logic [3:0] KW_PRIVATE   = 4'd4;
  localparam logic [3:0] KW_MAX_AGE   = 4'd8;
  localparam logic [3:0] KW_S_MAXAGE  = 4'd9;

  // flag bits
  localparam int unsigned FLAG_PRESENT     = 0;
  localparam int unsigned FLAG_PRIV_QUAL   = 9;
  localparam int unsigned FLAG_PRIV_BARE   = 10;
  localparam int unsigned FLAG_NC_QUAL     = 11;
  localparam int unsigned FLAG_NC_BARE     = 12;
  localparam int unsigned FLAG_S_MAXAGE    = 13;

  // characters
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_EQUALS = 8'h3D;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_BIT  = 8'h20;

  localparam logic [VALUE_W-1:0] VALUE_MAX = '1;

  // right-aligned text, first character in the highest used byte
  localparam logic [127:0] KW_TEXT [KW_NUM] = '{
    "no-cache", "must-revalidate", "proxy-revalidate", "no-store",
    "private", "public", "immutable", "no-transform", "max-age", "s-maxage"
  };
  localparam logic [POS_W-1:0] KW_LEN [KW_NUM] = '{
    5'd8, 5'd15, 5'd16, 5'd8, 5'd7, 5'd6, 5'd9, 5'd12, 5'd7, 5'd8
  };

  typedef enum logic [1:0] {
    TP_LEAD,
    TP_NAME,
    TP_GAP,
    TP_VALUE
  } tok_phase_e;

  typedef enum logic [2:0] {
    NP_LEAD,
    NP_OPENQ,
    NP_DIGITS,
    NP_SPACE,
    NP_QUOTE
  } num_phase_e;

  typedef struct packed {
    logic [KW_NUM-1:0]  cand;
    logic [POS_W-1:0]   pos;
    tok_phase_e         tp;
    logic               eq;
    logic [VALUE_W-1:0] num;
    num_phase_e         np;
    logic               fail;
    logic               sat;
  } tok_t;

  typedef struct packed {
    logic [FLAGS_W-1:0] flags;
    logic [VALUE_W-1:0] max_age;
    logic               max_age_seen;
    logic [VALUE_W-1:0] s_max_age;
  } acc_t;

  localparam tok_t TOK_RESET = '{
    cand: '1, pos: '0, tp: TP_LEAD, eq: 1'b0, num: '0, np: NP_LEAD,
    fail: 1'b0, sat: 1'b0
  };

  // character p of keyword k; zero past its end
  function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [POS_W-1:0] p);
    logic [127:0]     txt;
    logic [POS_W-1:0] len;
    logic [3:0]       off;
    txt = KW_TEXT[k];
    len = KW_LEN[k];
    off = 4'(len - 5'd1 - p);
    if (p < len) begin
      return txt[{off, 3'b000} +: 8];
    end
    return 8'h00;
  endfunction

endpackage

[hdl/ccp_parser.sv]
module ccp_parser import ccp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] data_byte_i,
  input  logic       byte_present_i,
  input  logic       line_end_i,
  input  logic       new_response_i,
  output acc_t       acc_d_o
);

  tok_t tok_q, tok_d;
  acc_t acc_q, acc_d;

  // next state: clear, consume byte, close directive
  always_comb begin
    tok_t               t0;
    tok_t               t1;
    acc_t               a0;
    logic [7:0]         c;
    logic [7:0]         lc;
    logic               is_comma;
    logic               is_digit;
    logic               is_space;
    logic               is_quote;
    logic               do_digit;
    logic [35:0]        prod;
    logic               found;
    logic [3:0]         hit;
    logic [VALUE_W-1:0] value;

    t0       = new_response_i ? TOK_RESET : tok_q;
    a0       = new_response_i ? acc_t'('0) : acc_q;
    c        = data_byte_i;
    is_comma = byte_present_i && (c == CH_COMMA);
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    is_space = (c == CH_SPACE);
    is_quote = (c == CH_QUOTE);
    lc       = ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ? (c | CASE_BIT) : c;
    do_digit = 1'b0;
    prod     = {4'b0, t0.num} * 36'd10 + {32'b0, 4'(c - CH_ZERO)};
    t1       = t0;

    if (byte_present_i && !is_comma) begin
      if (t0.tp != TP_VALUE) begin
        if (is_space) begin
          if (t0.tp == TP_NAME) t1.tp = TP_GAP;
        end else if (c == CH_EQUALS) begin
          t1.tp = TP_VALUE;
          t1.eq = 1'b1;
        end else begin
          if (t0.tp == TP_GAP) t1.cand = '0;
          for (int i = 0; i < KW_NUM; i++) begin
            if (!((t0.pos < KW_LEN[i]) && (kw_char(4'(i), t0.pos) == lc))) begin
              t1.cand[i] = 1'b0;
            end
          end
          if (t0.pos != '1) t1.pos = t0.pos + 5'd1;
          t1.tp = TP_NAME;
        end
      end else if (!t0.fail && !t0.sat) begin
        case (t0.np)
          NP_LEAD, NP_OPENQ: begin
            if (is_space) begin
              t1.np = t0.np;
            end else if (is_quote) begin
              t1.np = (t0.np == NP_LEAD) ? NP_OPENQ : NP_QUOTE;
            end else if (is_digit) begin
              t1.np    = NP_DIGITS;
              do_digit = 1'b1;
            end else begin
              t1.fail = 1'b1;
            end
          end
          NP_DIGITS: begin
            if (is_digit)      do_digit = 1'b1;
            else if (is_space) t1.np = NP_SPACE;
            else if (is_quote) t1.np = NP_QUOTE;
            else               t1.fail = 1'b1;
          end
          default: begin
            if (!is_space) t1.fail = 1'b1;
          end
        endcase
        if (do_digit) begin
          if (prod[35:32] != 4'd0) begin
            t1.num = VALUE_MAX;
            t1.sat = 1'b1;
          end else begin
            t1.num = prod[31:0];
          end
        end
      end
    end

    // close the pending directive
    found = 1'b0;
    hit   = '0;
    for (int i = 0; i < KW_NUM; i++) begin
      if (!found && t1.cand[i] && (t1.pos == KW_LEN[i])) begin
        found = 1'b1;
        hit   = 4'(i);
      end
    end
    value = t1.fail ? '0 : t1.num;
    acc_d = a0;
    tok_d = t1;
    if (is_comma || line_end_i) begin
      tok_d = TOK_RESET;
      if ((t1.tp != TP_LEAD) && found) begin
        if (hit < KW_MAX_AGE) begin
          acc_d.flags[hit + 4'd1] = 1'b1;
          if (hit == KW_PRIVATE) begin
            if (t1.eq) acc_d.flags[FLAG_PRIV_QUAL] = 1'b1;
            else       acc_d.flags[FLAG_PRIV_BARE] = 1'b1;
          end
          if (hit == KW_NO_CACHE) begin
            if (t1.eq) acc_d.flags[FLAG_NC_QUAL] = 1'b1;
            else       acc_d.flags[FLAG_NC_BARE] = 1'b1;
          end
        end else if (hit == KW_MAX_AGE) begin
          acc_d.max_age      = value;
          acc_d.max_age_seen = 1'b1;
        end else begin
          acc_d.s_max_age              = value;
          acc_d.flags[FLAG_S_MAXAGE]   = 1'b1;
        end
      end
    end
    if (line_end_i) acc_d.flags[FLAG_PRESENT] = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= TOK_RESET;
      acc_q <= '0;
    end else if (accept_i) begin
      tok_q <= tok_d;
      acc_q <= acc_d;
    end
  end

  assign acc_d_o = acc_d;

endmodule

[hdl/cache_control_header_parser_core.sv]
// Cache-Control directive parser.
// Input stream: one header-value byte per beat. s_axis_tlast marks the last
// beat of a header line; tuser bit 0 says the byte is valid (a beat with it
// low and tlast high is an empty line), tuser bit 1 starts a new response and
// clears all accumulated flags and values before the beat is used.
// Output stream: one beat per header line, carrying the accumulated directive
// flags, max-age (with its seen bit) and s-maxage, both saturating at 2^32-1.
// Latency: the result beat is valid the cycle after the line's last input
// beat is taken. Throughput: one input beat per cycle while not stalled;
// each byte goes through a single pass of match/accumulate logic into the
// parser registers, and the result register decouples the two sides.
// Stall: while a result waits in the output register and m_axis_tready is
// low, s_axis_tready is low; otherwise input beats keep flowing.
// Reset: all flags and values are cleared, the directive parser returns to
// its leading-space phase and the output holds no beat.
`include "cache_control_header_parser_core_assert.svh"

module cache_control_header_parser_core import ccp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,  // [7:0] data_byte
  input  logic [S_TUSER_W-1:0] s_axis_tuser,  // [0] byte_present, [1] new_response
  input  logic                 s_axis_tlast,  // line_end
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [13:0] directive_flags, [45:14] max_age_seconds, [46] max_age_seen,
  // [78:47] shared_max_age_seconds, [79] zero
  output logic [M_TDATA_W-1:0] m_axis_tdata
);

  logic accept;
  acc_t acc_d;
  acc_t res_q;
  logic out_valid_q;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  ccp_parser u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .data_byte_i    (s_axis_tdata[7:0]),
    .byte_present_i (s_axis_tuser[0]),
    .line_end_i     (s_axis_tlast),
    .new_response_i (s_axis_tuser[1]),
    .acc_d_o        (acc_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept && s_axis_tlast) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && s_axis_tlast) begin
      res_q <= acc_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, res_q.s_max_age, res_q.max_age_seen, res_q.max_age,
                          res_q.flags};

  `CCP_ASSERT_IMP(a_present_bit, m_axis_tvalid, m_axis_tdata[0], "result beat without present flag")
  `CCP_ASSERT_NXT(a_line_gives_beat, accept && s_axis_tlast, m_axis_tvalid, "line end gave no result beat")
  `CCP_ASSERT_NXT(a_no_spurious_beat, accept && !s_axis_tlast && (!m_axis_tvalid || m_axis_tready), !m_axis_tvalid, "result beat without line end")
  `CCP_ASSERT_NXT(a_fresh_empty_line, accept && s_axis_tlast && s_axis_tuser[1] && !s_axis_tuser[0], (m_axis_tdata[13:0] == 14'h1) && (m_axis_tdata[78:14] == '0), "empty line after clear gave stale state")

endmodule
